### design/bba_pkg.sv
// Shared types, constants and helper functions for the bitmap block allocator.
// Used by bitmap_block_allocator; has no dependencies of its own.
package bba_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_FREE = 5'b00100,
        S_DONE = 5'b01000,
        S_HOLD = 5'b10000
    } state_t;

    // Position of the lowest clear bit of a map word; the caller checks that one exists.
    function automatic logic [BIT_AW-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
        logic [BIT_AW-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                pos = BIT_AW'(i);
            end
        end
        return pos;
    endfunction

endpackage

### design/bitmap_block_allocator.sv
// First-fit bitmap block allocator: top level with the scan sequencer.
// Depends on bba_pkg and bba_ram (the 16 x 64 allocation map).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per beat: command 0
//   allocates the lowest free block, command 1 frees block_index. The output
//   channel (out_valid/out_ready) returns one beat per request with status,
//   result_index and the free count after the request.
//   in_ready is high only while the sequencer is idle; one request is handled
//   at a time. An allocate reads the map one 64-bit word per cycle through a
//   single priority encoder, walking the words in order from word 0 until it
//   finds the first one with a clear bit, and then loads the result register.
//   An allocate with no free block loads it straight from the idle state, and
//   a free first reads the block's word, writing it back only if it was set.
//   The sequencer is idle again after the edge that copies the result into
//   the output register.
//   If the receiver stalls, a finished result waits in the sequencer until
//   the output register empties, and in_ready stays low meanwhile.
//   Reset clears the per-word valid bits, so every block reads as free at
//   once, and sets the free count to the full block count.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             command,
    input  logic [IDX_W-1:0] block_index,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [IDX_W-1:0] result_index,
    output logic [CNT_W-1:0] free_count
);

    state_t                 state_reg, state_next;
    logic [WORD_AW-1:0]     word_reg, word_next;
    logic [BIT_AW-1:0]      bit_reg, bit_next;
    logic [MAP_WORDS-1:0]   row_valid_reg, row_valid_next;
    logic [CNT_W-1:0]       free_total_reg, free_total_next;
    status_t                res_status_reg, res_status_next;
    logic [IDX_W-1:0]       res_index_reg, res_index_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [IDX_W-1:0]       out_index_reg, out_index_next;
    logic [CNT_W-1:0]       out_count_reg, out_count_next;

    logic                   ram_we;
    logic [WORD_AW-1:0]     ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [WORD_AW-1:0]     ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;
    logic [WORD_BITS-1:0]   map_word;
    logic [BIT_AW-1:0]      zero_pos;
    logic                   accept;
    logic                   out_free;

    bba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // A row never written since reset reads as all free.
    assign map_word = row_valid_reg[word_reg] ? ram_rdata : '0;
    assign zero_pos = lowest_zero(map_word);

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        row_valid_next  = row_valid_reg;
        free_total_next = free_total_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = word_reg;
        ram_wdata       = map_word;
        ram_raddr       = word_reg + WORD_AW'(1);

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = '0;
                if (in_valid && command == CMD_FREE)
                begin
                    ram_raddr = block_index[IDX_W-1:BIT_AW];
                end
                if (accept)
                begin
                    if (command == CMD_FREE)
                    begin
                        word_next  = block_index[IDX_W-1:BIT_AW];
                        bit_next   = block_index[BIT_AW-1:0];
                        state_next = S_FREE;
                    end
                    else if (free_total_reg == '0)
                    begin
                        res_status_next = ST_NONE_FREE;
                        res_index_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        word_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // rdata holds word word_reg; the next word is already being fetched.
                if (~map_word != '0)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = map_word | (WORD_BITS'(1) << zero_pos);
                    row_valid_next[word_reg] = 1'b1;
                    free_total_next = free_total_reg - CNT_W'(1);
                    res_status_next = ST_ALLOCATED;
                    res_index_next  = IDX_W'({word_reg, zero_pos});
                    state_next      = S_DONE;
                end
                else if (word_reg == WORD_AW'(MAP_WORDS - 1))
                begin
                    res_status_next = ST_NONE_FREE;
                    res_index_next  = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    word_next = word_reg + WORD_AW'(1);
                end
            end

            S_FREE:
            begin
                ram_raddr = word_reg;
                if (map_word[bit_reg])
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = map_word & ~(WORD_BITS'(1) << bit_reg);
                    row_valid_next[word_reg] = 1'b1;
                    if (free_total_reg < CNT_W'(NUM_BLOCKS))
                    begin
                        free_total_next = free_total_reg + CNT_W'(1);
                    end
                    res_status_next = ST_FREED;
                    res_index_next  = IDX_W'({word_reg, bit_reg});
                end
                else
                begin
                    res_status_next = ST_IGNORED;
                    res_index_next  = '0;
                end
                state_next = S_DONE;
            end

            S_DONE, S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    out_count_next  = free_total_reg;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            row_valid_reg  <= '0;
            free_total_reg <= CNT_W'(NUM_BLOCKS);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_valid_reg  <= row_valid_next;
            free_total_reg <= free_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_index = out_index_reg;
    assign free_count   = out_count_reg;

endmodule

### design/bba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
